@@ rtl/core/particle_update_step_macros.svh @@
// Assertion helpers for the particle update block
`ifndef PARTICLE_UPDATE_STEP_MACROS_SVH
`define PARTICLE_UPDATE_STEP_MACROS_SVH
// Check an implication on every rising clock edge outside reset
`define PUS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication in the cycle after the antecedent
`define PUS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/pus_pkg.sv @@
`timescale 1ns / 1ps
package pus_pkg;

  localparam int unsigned NumCfgRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] RegGravX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGravY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGravZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColS = 3'd3;
  localparam logic [CfgIdxW-1:0] RegColM = 3'd4;
  localparam logic [CfgIdxW-1:0] RegColE = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAlpha = 3'd6;
  localparam logic [CfgIdxW-1:0] RegScale = 3'd7;

  localparam logic signed [31:0] DeadAge = -32'sd65536;
  localparam logic signed [31:0] RstGravY = -32'sd602931;
  localparam logic [47:0] RstColor = 48'h800080008000;
  localparam logic [47:0] RstAlpha = 48'h000040008000;
  localparam logic [47:0] RstScale = 48'h010001000100;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] age;
    logic [30:0] lifetime;
    logic [15:0] time_step;
  } pus_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_age;
    logic [15:0] color_r;
    logic [15:0] color_g;
    logic [15:0] color_b;
    logic [15:0] alpha;
    logic [15:0] scale;
  } pus_out_t;

  typedef struct packed {
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic signed [31:0] grav_z;
    logic [47:0] col_s;
    logic [47:0] col_m;
    logic [47:0] col_e;
    logic [47:0] alpha_k;
    logic [47:0] scale_k;
  } pus_cfg_t;

  // Saturate a 49-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) r = 32'sh7fffffff;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/core/particle_update_step.sv @@
`timescale 1ns / 1ps
// Particle update step: one particle enters per cycle while in_stall is low; its
// result passes through stage 1 (age, liveness, phase numerator and integration
// products), stage 2 (saturated integration sums), 16 stages of a bit-per-stage
// phase divider and one stage of blend products, then the blend sum goes into
// the output register. The integrator results ride along the divider pipe. A
// stall at the output freezes the whole pipe; in_stall is high while a result
// waits at the output under out_stall.
module particle_update_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pus_pkg::pus_in_t              in_data_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pus_pkg::pus_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pus_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pus_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned SideW = 7*32 + 2;

  pus_pkg::pus_cfg_t cfg;
  logic adv;

  pus_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // Whole pipe advances unless a finished result is blocked
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: age, liveness, phase numerator, integration products
  logic              s1_vld_q;
  pus_pkg::pus_in_t  s1_in_q;
  logic signed [31:0] s1_age_q;
  logic              s1_alive_q, s1_half_q;
  logic [47:0]       s1_num_q;
  logic signed [48:0] s1_pv_q [3];
  logic signed [48:0] s1_gv_q [3];

  logic signed [31:0] age_d;
  logic              alive_d, half_d;
  logic [31:0]       a2_d;
  logic [31:0]       rel_d;
  logic signed [31:0] vel_d [3];
  logic signed [31:0] grv_d [3];

  always_comb begin
    age_d   = pus_pkg::sat32(49'(in_data_i.age) + 49'(in_data_i.time_step));
    alive_d = (in_data_i.lifetime != '0) && (age_d < $signed({1'b0, in_data_i.lifetime}));
    a2_d    = age_d[31] ? 32'd0 : {age_d[30:0], 1'b0};
    half_d  = a2_d >= {1'b0, in_data_i.lifetime};
    rel_d   = half_d ? (a2_d - {1'b0, in_data_i.lifetime}) : a2_d;
    vel_d[0] = in_data_i.vel_x; vel_d[1] = in_data_i.vel_y; vel_d[2] = in_data_i.vel_z;
    grv_d[0] = cfg.grav_x;      grv_d[1] = cfg.grav_y;      grv_d[2] = cfg.grav_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= in_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_in_q    <= in_data_i;
      s1_age_q   <= age_d;
      s1_alive_q <= alive_d;
      s1_half_q  <= half_d;
      s1_num_q   <= {rel_d[31:0], 16'h0000};
      for (int i = 0; i < 3; i++) begin
        s1_pv_q[i] <= vel_d[i] * $signed({1'b0, in_data_i.time_step});
        s1_gv_q[i] <= grv_d[i] * $signed({1'b0, in_data_i.time_step});
      end
    end
  end

  // Stage 2: shift and saturate the integration sums
  logic              s2_vld_q;
  logic              s2_alive_q, s2_half_q;
  logic signed [31:0] s2_age_q;
  logic [47:0]       s2_num_q;
  logic [30:0]       s2_life_q;
  logic signed [31:0] s2_pos_q [3];
  logic signed [31:0] s2_vel_q [3];
  logic signed [31:0] base_p [3];

  always_comb begin
    base_p[0] = s1_in_q.pos_x; base_p[1] = s1_in_q.pos_y; base_p[2] = s1_in_q.pos_z;
  end

  function automatic logic signed [31:0] vel_at(input int k);
    logic signed [31:0] r;
    case (k)
      0: r = s1_in_q.vel_x;
      1: r = s1_in_q.vel_y;
      default: r = s1_in_q.vel_z;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_alive_q <= s1_alive_q;
      s2_half_q  <= s1_half_q;
      s2_age_q   <= s1_age_q;
      s2_num_q   <= s1_num_q;
      s2_life_q  <= s1_in_q.lifetime;
      for (int i = 0; i < 3; i++) begin
        // Arithmetic shift floors toward minus infinity
        if (s1_alive_q) begin
          s2_pos_q[i] <= pus_pkg::sat32(49'(base_p[i]) + (s1_pv_q[i] >>> 16));
          s2_vel_q[i] <= pus_pkg::sat32(49'(vel_at(i)) + (s1_gv_q[i] >>> 16));
        end else begin
          s2_pos_q[i] <= base_p[i];
          s2_vel_q[i] <= vel_at(i);
        end
      end
    end
  end

  // Divider: phase t = rel * 65536 / lifetime
  logic [SideW-1:0] side_in, side_out;
  logic             dv_vld;
  logic [15:0]      t_q;

  assign side_in = {s2_pos_q[0], s2_pos_q[1], s2_pos_q[2],
                    s2_vel_q[0], s2_vel_q[1], s2_vel_q[2],
                    s2_age_q, s2_alive_q, s2_half_q};

  pus_divider #(.NumW(48), .DenW(31), .QW(16), .SideW(SideW)) u_div (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s2_vld_q),
    .num_i(s2_num_q), .den_i(s2_life_q | {30'd0, ~|s2_life_q}), .side_i(side_in),
    .valid_o(dv_vld), .quo_o(t_q), .side_o(side_out)
  );

  logic d_half;
  assign d_half  = side_out[0];

  // Key selection
  logic [15:0] key_s [5];
  logic [15:0] key_e [5];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      key_s[c] = d_half ? cfg.col_m[16*c +: 16] : cfg.col_s[16*c +: 16];
      key_e[c] = d_half ? cfg.col_e[16*c +: 16] : cfg.col_m[16*c +: 16];
    end
    key_s[3] = d_half ? cfg.alpha_k[31:16] : cfg.alpha_k[15:0];
    key_e[3] = d_half ? cfg.alpha_k[47:32] : cfg.alpha_k[31:16];
    key_s[4] = d_half ? cfg.scale_k[31:16] : cfg.scale_k[15:0];
    key_e[4] = d_half ? cfg.scale_k[47:32] : cfg.scale_k[31:16];
  end

  // Blend stage A: the two products per channel
  logic             b1_vld_q;
  logic [SideW-1:0] b1_side_q;
  logic [32:0]      b1_ps_q [5];
  logic [31:0]      b1_pe_q [5];
  logic [16:0]      inv_t;
  assign inv_t = 17'h10000 - {1'b0, t_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b1_vld_q <= 1'b0;
    else if (adv) b1_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_side_q <= side_out;
      for (int c = 0; c < 5; c++) begin
        b1_ps_q[c] <= key_s[c] * inv_t;
        b1_pe_q[c] <= key_e[c] * t_q;
      end
    end
  end

  // Blend stage B: sum, drop fraction, assemble result
  pus_pkg::pus_out_t res_d, out_q;
  logic              out_vld_q;
  logic [33:0]       bsum [5];

  always_comb begin
    for (int c = 0; c < 5; c++) bsum[c] = {1'b0, b1_ps_q[c]} + {2'b00, b1_pe_q[c]};
    res_d.new_pos_x = b1_side_q[SideW-1 -: 32];
    res_d.new_pos_y = b1_side_q[SideW-33 -: 32];
    res_d.new_pos_z = b1_side_q[SideW-65 -: 32];
    res_d.new_vel_x = b1_side_q[SideW-97 -: 32];
    res_d.new_vel_y = b1_side_q[SideW-129 -: 32];
    res_d.new_vel_z = b1_side_q[SideW-161 -: 32];
    if (b1_side_q[1]) begin
      res_d.new_age = b1_side_q[SideW-193 -: 32];
      res_d.color_r = bsum[0][31:16];
      res_d.color_g = bsum[1][31:16];
      res_d.color_b = bsum[2][31:16];
      res_d.alpha   = bsum[3][31:16];
      res_d.scale   = bsum[4][31:16];
    end else begin
      res_d.new_age = pus_pkg::DeadAge;
      res_d.color_r = '0;
      res_d.color_g = '0;
      res_d.color_b = '0;
      res_d.alpha   = '0;
      res_d.scale   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= b1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= res_d;
  end

  assign out_valid  = out_vld_q;
  assign out_data_o = out_q;

endmodule

@@ rtl/core/pus_divider.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: 16-bit quotient of num / den, one quotient bit
// per stage, with a side payload carried alongside. The high NumW-QW bits of
// num form the starting remainder and must be below den.
module pus_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 31,
  parameter int unsigned QW = 16,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quo_o,
  output logic [SideW-1:0] side_o
);

  logic [QW:1]            vld_q;
  logic [DenW:0]          rem_q  [1:QW];
  logic [NumW-1:0]        num_q  [1:QW];
  logic [DenW-1:0]        den_q  [1:QW];
  logic [QW-1:0]          quo_q  [1:QW];
  logic [SideW-1:0]       side_q [1:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[QW-1:1], valid_i};
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DenW:0]    rem_in;
    logic [NumW-1:0]  num_in;
    logic [DenW-1:0]  den_in;
    logic [QW-1:0]    quo_in;
    logic [SideW-1:0] side_in;
    logic [DenW+1:0]  trial_d;
    logic [DenW+1:0]  diff_d;
    if (s == 0) begin : g_first
      // Start from the high part of the numerator as the partial remainder
      assign rem_in  = num_i[NumW-1:QW];
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s];
      assign num_in  = num_q[s];
      assign den_in  = den_q[s];
      assign quo_in  = quo_q[s];
      assign side_in = side_q[s];
    end
    always_comb begin
      // Bring down the next numerator bit, counting from bit QW-1-s of the low part
      trial_d = {rem_in, num_in[QW-1-s]};
      diff_d  = trial_d - {2'b00, den_in};
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (!diff_d[DenW+1]) begin
          rem_q[s+1] <= diff_d[DenW:0];
          quo_q[s+1] <= {quo_in[QW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= trial_d[DenW:0];
          quo_q[s+1] <= {quo_in[QW-2:0], 1'b0};
        end
        num_q[s+1]  <= num_in;
        den_q[s+1]  <= den_in;
        side_q[s+1] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule

@@ rtl/core/pus_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file
module pus_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pus_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pus_pkg::CfgDataW-1:0]  cfg_data_i,
  output pus_pkg::pus_cfg_t             cfg_o
);

  pus_pkg::pus_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grav_x  <= '0;
      cfg_q.grav_y  <= pus_pkg::RstGravY;
      cfg_q.grav_z  <= '0;
      cfg_q.col_s   <= pus_pkg::RstColor;
      cfg_q.col_m   <= pus_pkg::RstColor;
      cfg_q.col_e   <= pus_pkg::RstColor;
      cfg_q.alpha_k <= pus_pkg::RstAlpha;
      cfg_q.scale_k <= pus_pkg::RstScale;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pus_pkg::RegGravX: cfg_q.grav_x  <= cfg_data_i[31:0];
        pus_pkg::RegGravY: cfg_q.grav_y  <= cfg_data_i[31:0];
        pus_pkg::RegGravZ: cfg_q.grav_z  <= cfg_data_i[31:0];
        pus_pkg::RegColS:  cfg_q.col_s   <= cfg_data_i;
        pus_pkg::RegColM:  cfg_q.col_m   <= cfg_data_i;
        pus_pkg::RegColE:  cfg_q.col_e   <= cfg_data_i;
        pus_pkg::RegAlpha: cfg_q.alpha_k <= cfg_data_i;
        pus_pkg::RegScale: cfg_q.scale_k <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/pus_checker.sv @@
`timescale 1ns / 1ps
`include "particle_update_step_macros.svh"
// Port-level checks for the particle update block
module pus_port_checks (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input pus_pkg::pus_out_t out_data_o
);

  // Hold a stalled result
  `PUS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall,
    out_valid && $stable(out_data_o), "stalled result changed")
  // Stall the input only under output backpressure
  `PUS_ASSERT_IMP(a_in_stall_src, clk_i, rst_ni, in_stall, out_valid && out_stall,
    "input stalled without output backpressure")
  // Keep the handshake outputs known
  `PUS_ASSERT_IMP(a_ctrl_known, clk_i, rst_ni, 1'b1,
    !$isunknown(out_valid) && !$isunknown(in_stall), "handshake output unknown")

endmodule

bind particle_update_step pus_port_checks u_pus_port_checks (
  .clk_i, .rst_ni, .in_stall, .out_valid, .out_stall, .out_data_o
);
